// ===== src/assert_macros.svh =====
// Assertion macros shared by the console cursor RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never be seen outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    `ASSERT_CLK(label, clk, rst_n, !(cond), msg)

`endif

// ===== src/tccc_pkg.sv =====
// Types, codes and constants of the console cursor controller
package tccc_pkg;

    localparam logic [7:0] COLS_RESET  = 8'd80;
    localparam logic [7:0] ROWS_RESET  = 8'd25;
    localparam logic [7:0] GLYPH_SPACE = 8'd32;
    localparam logic [7:0] GLYPH_NONE  = 8'd0;

    // tab stops every four columns, at most eight spaces
    localparam int unsigned TAB_STOP_BITS = 2;
    localparam int unsigned TAB_CNT_W     = 3;
    localparam logic [TAB_CNT_W-1:0] TAB_CNT_LAST = '1;

    localparam logic [2:0] FUNC_PRINT     = 3'd0;
    localparam logic [2:0] FUNC_NEWLINE   = 3'd1;
    localparam logic [2:0] FUNC_BACKSPACE = 3'd2;
    localparam logic [2:0] FUNC_TAB       = 3'd3;
    localparam logic [2:0] FUNC_CLEAR     = 3'd4;

    localparam logic [1:0] CMD_DRAW   = 2'd0;
    localparam logic [1:0] CMD_SPAN   = 2'd1;
    localparam logic [1:0] CMD_SCROLL = 2'd2;
    localparam logic [1:0] CMD_CLS    = 2'd3;

    localparam logic CFG_COLS = 1'b0;
    localparam logic CFG_ROWS = 1'b1;

    typedef struct packed {
        logic [2:0] func;
        logic [7:0] char_code;
    } in_word_t;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] col_first;
        logic [7:0] col_last;
        logic [7:0] row;
        logic [7:0] glyph;
        logic       last;
    } out_word_t;

    typedef enum logic [3:0] {
        STEP_NONE,
        STEP_ACCEPT,
        STEP_PR_SCROLL,
        STEP_PR_WRAP,
        STEP_PR_DRAW,
        STEP_NL_SPAN,
        STEP_NL_ROW,
        STEP_BS,
        STEP_CLR
    } step_t;

    typedef struct packed {
        step_t step;
        logic  go;
    } dp_cmd_t;

    typedef struct packed {
        logic emit;
        logic tab_more;
    } dp_sts_t;

endpackage

// ===== src/tccc_ctrl.sv =====
// Step sequencer and output valid flag of the console cursor controller
`include "assert_macros.svh"

module tccc_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [2:0]        s_func,
    output logic              m_valid,
    input  logic              m_ready,
    output tccc_pkg::dp_cmd_t cmd,
    input  tccc_pkg::dp_sts_t sts
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PR_SCROLL,
        ST_PR_WRAP,
        ST_PR_DRAW,
        ST_NL_SPAN,
        ST_NL_ROW,
        ST_BS,
        ST_CLR
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;
    logic   load;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign load     = cmd.go && sts.emit;

    always_comb begin
        unique case (state_reg)
            ST_IDLE:      cmd.step = tccc_pkg::STEP_ACCEPT;
            ST_PR_SCROLL: cmd.step = tccc_pkg::STEP_PR_SCROLL;
            ST_PR_WRAP:   cmd.step = tccc_pkg::STEP_PR_WRAP;
            ST_PR_DRAW:   cmd.step = tccc_pkg::STEP_PR_DRAW;
            ST_NL_SPAN:   cmd.step = tccc_pkg::STEP_NL_SPAN;
            ST_NL_ROW:    cmd.step = tccc_pkg::STEP_NL_ROW;
            ST_BS:        cmd.step = tccc_pkg::STEP_BS;
            ST_CLR:       cmd.step = tccc_pkg::STEP_CLR;
            default:      cmd.step = tccc_pkg::STEP_NONE;
        endcase
        if (state_reg == ST_IDLE) begin
            cmd.go = s_valid;
        end else begin
            cmd.go = !sts.emit || out_free;
        end
    end

    always_comb begin
        state_next = state_reg;
        if (cmd.go) begin
            unique case (state_reg)
                ST_IDLE: begin
                    unique case (s_func)
                        tccc_pkg::FUNC_PRINT:     state_next = ST_PR_SCROLL;
                        tccc_pkg::FUNC_TAB:       state_next = ST_PR_SCROLL;
                        tccc_pkg::FUNC_NEWLINE:   state_next = ST_NL_SPAN;
                        tccc_pkg::FUNC_BACKSPACE: state_next = ST_BS;
                        tccc_pkg::FUNC_CLEAR:     state_next = ST_CLR;
                        default:                  state_next = ST_IDLE;
                    endcase
                end
                ST_PR_SCROLL: state_next = ST_PR_WRAP;
                ST_PR_WRAP:   state_next = ST_PR_DRAW;
                ST_PR_DRAW:   state_next = sts.tab_more ? ST_PR_SCROLL : ST_IDLE;
                ST_NL_SPAN:   state_next = ST_NL_ROW;
                default:      state_next = ST_IDLE;
            endcase
        end
        if (load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    `ASSERT_CLK(a_valid_from_load, aclk, aresetn, $rose(m_valid_reg) |-> $past(load), "output word appeared without a load")
    `ASSERT_NEVER(a_load_needs_room, aclk, aresetn, load && !out_free, "output word overwritten before it was taken")

endmodule

// ===== src/tccc_dp.sv =====
// Cursor, size registers and output word register of the console cursor controller
`include "assert_macros.svh"

module tccc_dp (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic                cfg_index,
    input  logic [7:0]          cfg_wr_data,
    input  tccc_pkg::in_word_t  s_data,
    input  tccc_pkg::dp_cmd_t   cmd,
    output tccc_pkg::dp_sts_t   sts,
    output tccc_pkg::out_word_t m_data
);

    logic [7:0] cols_reg, rows_reg;
    logic [7:0] col_reg, col_next;
    logic [7:0] row_reg, row_next;
    logic [tccc_pkg::TAB_CNT_W-1:0] tab_cnt_reg;
    logic       is_tab_reg;
    logic [7:0] glyph_reg;
    tccc_pkg::out_word_t out_reg, word;

    logic [7:0] cols_eff, rows_eff;
    logic [8:0] row_inc;
    logic       row_wraps;
    logic [7:0] row_adv;
    logic       col_at_end;
    logic [7:0] col_inc;
    logic [7:0] cfg_cols, cfg_rows, cfg_cols_eff, cfg_rows_eff;
    logic       emit_now;
    logic       tab_more;
    logic       draw_go;

    assign cols_eff   = (cols_reg == 8'd0) ? 8'd1 : cols_reg;
    assign rows_eff   = (rows_reg == 8'd0) ? 8'd1 : rows_reg;
    assign row_inc    = {1'b0, row_reg} + 9'd1;
    assign row_wraps  = row_inc >= {1'b0, rows_eff};
    assign row_adv    = row_wraps ? (rows_eff - 8'd1) : row_inc[7:0];
    assign col_at_end = col_reg >= cols_eff;
    assign col_inc    = col_reg + 8'd1;

    assign tab_more = is_tab_reg
                   && (col_inc[tccc_pkg::TAB_STOP_BITS-1:0] != '0)
                   && (tab_cnt_reg != tccc_pkg::TAB_CNT_LAST);

    assign sts = '{emit: emit_now, tab_more: tab_more};

    assign cfg_cols     = (cfg_index == tccc_pkg::CFG_COLS) ? cfg_wr_data : cols_reg;
    assign cfg_rows     = (cfg_index == tccc_pkg::CFG_ROWS) ? cfg_wr_data : rows_reg;
    assign cfg_cols_eff = (cfg_cols == 8'd0) ? 8'd1 : cfg_cols;
    assign cfg_rows_eff = (cfg_rows == 8'd0) ? 8'd1 : cfg_rows;

    assign draw_go = cmd.go && (cmd.step == tccc_pkg::STEP_PR_DRAW);

    always_comb begin
        emit_now       = 1'b0;
        col_next       = col_reg;
        row_next       = row_reg;
        word.command   = tccc_pkg::CMD_SCROLL;
        word.col_first = 8'd0;
        word.col_last  = 8'd0;
        word.row       = 8'd0;
        word.glyph     = tccc_pkg::GLYPH_NONE;
        word.last      = 1'b0;
        unique case (cmd.step)
            tccc_pkg::STEP_PR_SCROLL: begin
                if (row_reg >= rows_eff) begin
                    emit_now = 1'b1;
                    row_next = rows_eff - 8'd1;
                    col_next = 8'd0;
                end
            end
            tccc_pkg::STEP_PR_WRAP: begin
                if (col_at_end) begin
                    emit_now = row_wraps;
                    col_next = 8'd0;
                    row_next = row_adv;
                end
            end
            tccc_pkg::STEP_PR_DRAW: begin
                emit_now       = 1'b1;
                word.command   = tccc_pkg::CMD_DRAW;
                word.col_first = col_reg;
                word.col_last  = col_reg;
                word.row       = row_reg;
                word.glyph     = glyph_reg;
                word.last      = !tab_more;
                col_next       = col_inc;
            end
            tccc_pkg::STEP_NL_SPAN: begin
                emit_now       = !col_at_end;
                word.command   = tccc_pkg::CMD_SPAN;
                word.col_first = col_reg;
                word.col_last  = cols_eff - 8'd1;
                word.row       = row_reg;
                word.last      = !row_wraps;
                col_next       = 8'd0;
            end
            tccc_pkg::STEP_NL_ROW: begin
                emit_now  = row_wraps;
                word.last = 1'b1;
                row_next  = row_adv;
            end
            tccc_pkg::STEP_BS: begin
                word.command = tccc_pkg::CMD_SPAN;
                word.last    = 1'b1;
                if (col_reg != 8'd0) begin
                    emit_now       = 1'b1;
                    col_next       = col_reg - 8'd1;
                    word.col_first = col_reg - 8'd1;
                    word.col_last  = col_reg - 8'd1;
                    word.row       = row_reg;
                end else if (row_reg != 8'd0) begin
                    emit_now       = 1'b1;
                    col_next       = cols_eff - 8'd1;
                    row_next       = row_reg - 8'd1;
                    word.col_first = cols_eff - 8'd1;
                    word.col_last  = cols_eff - 8'd1;
                    word.row       = row_reg - 8'd1;
                end
            end
            tccc_pkg::STEP_CLR: begin
                emit_now     = 1'b1;
                word.command = tccc_pkg::CMD_CLS;
                word.last    = 1'b1;
                col_next     = 8'd0;
                row_next     = 8'd0;
            end
            default: begin
                emit_now = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cols_reg    <= tccc_pkg::COLS_RESET;
            rows_reg    <= tccc_pkg::ROWS_RESET;
            col_reg     <= 8'd0;
            row_reg     <= 8'd0;
            tab_cnt_reg <= '0;
            is_tab_reg  <= 1'b0;
        end else if (cfg_wr_en) begin
            cols_reg <= cfg_cols;
            rows_reg <= cfg_rows;
            col_reg  <= (col_reg >= cfg_cols_eff) ? 8'd0 : col_reg;
            row_reg  <= (row_reg >= cfg_rows_eff) ? 8'd0 : row_reg;
        end else if (cmd.go) begin
            col_reg <= col_next;
            row_reg <= row_next;
            if (cmd.step == tccc_pkg::STEP_ACCEPT) begin
                tab_cnt_reg <= '0;
                is_tab_reg  <= (s_data.func == tccc_pkg::FUNC_TAB);
            end else if (cmd.step == tccc_pkg::STEP_PR_DRAW) begin
                tab_cnt_reg <= tab_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.go && cmd.step == tccc_pkg::STEP_ACCEPT) begin
            glyph_reg <= (s_data.func == tccc_pkg::FUNC_TAB) ? tccc_pkg::GLYPH_SPACE
                                                              : s_data.char_code;
        end
        if (cmd.go && emit_now) begin
            out_reg <= word;
        end
    end

    assign m_data = out_reg;

    `ASSERT_NEVER(a_row_in_screen, aclk, aresetn, row_reg >= rows_eff, "cursor row off screen")
    `ASSERT_NEVER(a_col_parked, aclk, aresetn, col_reg > cols_eff, "cursor column past parking")
    `ASSERT_NEVER(a_draw_in_screen, aclk, aresetn, draw_go && col_at_end, "draw outside screen")

endmodule

// ===== src/text_console_cursor_controller.sv =====
// Top level of the console cursor controller: sequencer plus datapath
//
//  channel  direction  word                 handshake
//  s_       in         func, char_code      s_valid / s_ready
//  m_       out        drawing command      m_valid / m_ready
//  cfg_     in         num_cols, num_rows   cfg_wr_en, no wait
//
// A word is taken in the idle state, then the steps run in order: print scroll, wrap, draw;
// tab scroll, wrap, draw for each space; newline span, row; backspace and clear one step each.
// A step that produces a command waits while the output register holds an untaken word.
// Synchronous active-low reset: 80 columns, 25 rows, cursor at column 0, row 0.
`include "assert_macros.svh"

module text_console_cursor_controller (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  tccc_pkg::in_word_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output tccc_pkg::out_word_t m_data,
    input  logic                cfg_wr_en,
    input  logic                cfg_index,
    input  logic [7:0]          cfg_wr_data
);

    tccc_pkg::dp_cmd_t cmd;
    tccc_pkg::dp_sts_t sts;

    tccc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_func  (s_data.func),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    tccc_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_data      (s_data),
        .cmd         (cmd),
        .sts         (sts),
        .m_data      (m_data)
    );

    `ASSERT_NEVER(a_no_take_mid_item, aclk, aresetn, s_valid && s_ready && m_valid && !m_data.last, "new word taken before the previous one finished")

endmodule
